/* hw/rtl/cunrank_pkg.sv */
// Shared constants, types and status codes for the combination unranking block.
// No dependencies; imported by cunrank_muldiv and combination_unrank_lex_top.
package cunrank_pkg;

	// Field widths of one input item and one result item.
	localparam int RANK_W = 64;
	localparam int N_W    = 7;
	localparam int K_W    = 6;

	// Bounds on the set size and on the reduced pick count min(k, n-k).
	localparam int MAX_N  = 75;
	localparam int MAX_RK = 20;

	// Multiply-divide unit: a product of a rank-wide value and a small factor,
	// divided by a small divisor four quotient bits per cycle.
	localparam int PROD_W     = RANK_W + N_W;
	localparam int DIGIT_BITS = 4;
	localparam int DVD_W      = ((PROD_W + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;
	localparam int DIGITS     = DVD_W / DIGIT_BITS;
	localparam int CNT_W      = $clog2(DIGITS);

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ERR   = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Request from the sequencer to the multiply-divide unit.
	typedef struct packed {
		logic           go;
		logic [N_W-1:0] mul;
		logic [N_W-1:0] div;
	} md_req_t;

endpackage

/* hw/rtl/cunrank_muldiv.sv */
// Shared multiply-divide unit: result = operand * mul / div, with an exact quotient.
// Depends on cunrank_pkg for widths and the request struct.
module cunrank_muldiv import cunrank_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  md_req_t           req,
	input  logic [RANK_W-1:0] operand,
	output logic              done,
	output logic [RANK_W-1:0] result
);

	typedef enum logic {
		MD_IDLE,
		MD_RUN
	} md_state_t;

	md_state_t          state_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [N_W-1:0]     rem_q;
	logic [N_W-1:0]     dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;

	logic [PROD_W-1:0]  prod;
	logic [DVD_W-1:0]   dvd_nx;
	logic [N_W-1:0]     rem_nx;

	assign prod = PROD_W'(operand) * PROD_W'(req.mul);

	// Four restoring division steps per cycle; quotient bits shift in at the bottom.
	always_comb begin
		logic [N_W:0]     t;
		logic [N_W-1:0]   r;
		logic [DVD_W-1:0] d;
		r = rem_q;
		d = dvd_q;
		t = '0;
		for (int b = 0; b < DIGIT_BITS; b++) begin
			t = {r, d[DVD_W-1]};
			d = {d[DVD_W-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t = t - {1'b0, dvs_q};
				d[0] = 1'b1;
			end
			r = t[N_W-1:0];
		end
		rem_nx = r;
		dvd_nx = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MD_IDLE: begin
					if (req.go) begin
						dvd_q   <= DVD_W'(prod);
						rem_q   <= '0;
						dvs_q   <= req.div;
						cnt_q   <= '0;
						state_q <= MD_RUN;
					end
				end
				MD_RUN: begin
					dvd_q <= dvd_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIGITS - 1)) begin
						done_q  <= 1'b1;
						state_q <= MD_IDLE;
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = dvd_q[RANK_W-1:0];

	a_no_go_while_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == MD_RUN) |-> !req.go)
		else $error("multiply-divide request while the unit is running");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> (req.div != '0))
		else $error("multiply-divide request with a zero divisor");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == MD_RUN) && (state_q == MD_IDLE))
		else $error("done raised without a finished division");

	a_exact_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(rem_nx) == '0))
		else $error("multiply-divide left a nonzero remainder");

endmodule

/* hw/rtl/combination_unrank_lex_top.sv */
// Top level of the lexicographic combination unranking block.
// Depends on cunrank_pkg and instantiates cunrank_muldiv.
//
// An item (rank, set_size n, pick_count k) is taken when start is high and busy is low.
// The block then answers with the k elements of the k-combination of {1..n} whose 1-based
// rank in ascending lexicographic order is rank, smallest element first, one result per
// cycle of strobe, with last set on the final one. The receiver cannot stall: every result
// is on element, last and status for exactly one cycle, so it must be captured when strobe
// is high. n above 75, k above n, rank 0, min(k, n-k) above 20 or rank above C(n,k) give a
// single result with status error and element 0; k = 0 with rank 1 gives a single result
// with status empty. All binomials are exact. Every binomial comes from one shared
// multiply-divide unit: first min(k, n-k) steps build C(n,k), then one step gives
// C(n-1,k-1), then one more step follows each candidate position the scan walks past or
// chooses, except the final pick. The scan visits at most n positions. Items rejected on
// the bounds alone are answered from the check, without a multiply-divide step. Busy
// stays high from the accepting edge until the edge that puts the final result out.
module combination_unrank_lex_top import cunrank_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [RANK_W-1:0] rank,
	input  logic [N_W-1:0]    set_size,
	input  logic [K_W-1:0]    pick_count,
	output logic              strobe,
	output logic [N_W-1:0]    element,
	output logic              last,
	output logic [1:0]        status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_BINOM,
		S_BWAIT,
		S_RCHK,
		S_CWAIT,
		S_SCAN
	} state_t;

	state_t            state_q;
	logic [RANK_W-1:0] rank_q;
	logic [N_W-1:0]    n_q;
	logic [K_W-1:0]    k_q;
	logic [K_W-1:0]    rk_q;
	logic [K_W-1:0]    i_q;
	logic [K_W-1:0]    j_q;
	logic [N_W-1:0]    z_q;
	logic [RANK_W-1:0] x_q;
	logic [RANK_W-1:0] c_q;
	md_req_t           req_q;

	logic              strobe_q;
	logic [N_W-1:0]    element_q;
	logic              last_q;
	status_t           status_q;

	logic              md_done;
	logic [RANK_W-1:0] md_result;

	// Bounds checks on the captured item.
	logic              bad_bounds;
	logic [N_W-1:0]    n_minus_k;
	logic [N_W-1:0]    rk7;
	logic              bad_rk;

	// Scan of candidate positions: m = n - z and r = k - j give the binomial C(m, r)
	// held in c_q, the count of combinations that keep z as the next element.
	logic [N_W-1:0]    m;
	logic [N_W-1:0]    r;
	logic              at_limit;
	logic [RANK_W:0]   x_diff;
	logic              x_lt_c;
	logic              final_pick;

	assign bad_bounds = (n_q > N_W'(MAX_N)) || (N_W'(k_q) > n_q) || (rank_q == '0);
	assign n_minus_k  = n_q - N_W'(k_q);
	assign rk7        = (N_W'(k_q) < n_minus_k) ? N_W'(k_q) : n_minus_k;
	assign bad_rk     = rk7 > N_W'(MAX_RK);

	assign m          = n_q - z_q;
	assign r          = N_W'(k_q) - N_W'(j_q);
	assign at_limit   = ({1'b0, z_q} + (N_W+1)'(k_q)) >= ({1'b0, n_q} + (N_W+1)'(j_q));
	assign x_diff     = {1'b0, x_q} - {1'b0, c_q};
	assign x_lt_c     = x_diff[RANK_W];
	assign final_pick = (j_q == k_q);

	cunrank_muldiv u_muldiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_q),
		.operand (c_q),
		.done    (md_done),
		.result  (md_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			req_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			req_q.go <= 1'b0;
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						rank_q  <= rank;
						n_q     <= set_size;
						k_q     <= pick_count;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (bad_bounds || bad_rk) begin
						strobe_q  <= 1'b1;
						element_q <= '0;
						last_q    <= 1'b1;
						status_q  <= ST_ERR;
						state_q   <= S_IDLE;
					end else begin
						// C(n, rk) is built as C(n-rk+i, i) for i = 1..rk.
						rk_q    <= rk7[K_W-1:0];
						c_q     <= RANK_W'(1);
						i_q     <= K_W'(1);
						state_q <= S_BINOM;
					end
				end
				S_BINOM: begin
					if (i_q > rk_q) begin
						state_q <= S_RCHK;
					end else begin
						req_q.go  <= 1'b1;
						req_q.mul <= n_q - N_W'(rk_q) + N_W'(i_q);
						req_q.div <= N_W'(i_q);
						state_q   <= S_BWAIT;
					end
				end
				S_BWAIT: begin
					if (md_done) begin
						c_q     <= md_result;
						i_q     <= i_q + 1'b1;
						state_q <= S_BINOM;
					end
				end
				S_RCHK: begin
					if (rank_q > c_q) begin
						strobe_q  <= 1'b1;
						element_q <= '0;
						last_q    <= 1'b1;
						status_q  <= ST_ERR;
						state_q   <= S_IDLE;
					end else if (k_q == '0) begin
						strobe_q  <= 1'b1;
						element_q <= '0;
						last_q    <= 1'b1;
						status_q  <= ST_EMPTY;
						state_q   <= S_IDLE;
					end else begin
						// First candidate count is C(n-1, k-1) = C(n, k) * k / n.
						x_q       <= rank_q - 1'b1;
						z_q       <= N_W'(1);
						j_q       <= K_W'(1);
						req_q.go  <= 1'b1;
						req_q.mul <= N_W'(k_q);
						req_q.div <= n_q;
						state_q   <= S_CWAIT;
					end
				end
				S_CWAIT: begin
					if (md_done) begin
						c_q     <= md_result;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (at_limit || x_lt_c) begin
						// z is chosen; the next count is C(m-1, r-1) = C(m, r) * r / m.
						strobe_q  <= 1'b1;
						element_q <= z_q;
						last_q    <= final_pick;
						status_q  <= ST_OK;
						if (final_pick) begin
							state_q <= S_IDLE;
						end else begin
							req_q.go  <= 1'b1;
							req_q.mul <= r;
							req_q.div <= m;
							z_q       <= z_q + 1'b1;
							j_q       <= j_q + 1'b1;
							state_q   <= S_CWAIT;
						end
					end else begin
						// Skip z; the next count is C(m-1, r) = C(m, r) * (m - r) / m.
						x_q       <= x_diff[RANK_W-1:0];
						req_q.go  <= 1'b1;
						req_q.mul <= m - r;
						req_q.div <= m;
						z_q       <= z_q + 1'b1;
						state_q   <= S_CWAIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign strobe  = strobe_q;
	assign element = element_q;
	assign last    = last_q;
	assign status  = status_q;

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_final_frees_block: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("block still busy after the final result");

	a_more_results_keep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("non-final result while the block is idle");

	a_non_ok_is_single: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status != ST_OK)) |-> (last && (element == '0)))
		else $error("error or empty result not a single zero result");

	a_element_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status == ST_OK)) |-> ((element != '0) && (element <= n_q)))
		else $error("chosen element outside 1..n");

endmodule
